/* sv/afccu_pkg.sv */
// Shared types, constants and the CRC step for the ADC frame checker.
package afccu_pkg;

  localparam int MAX_CHANNELS_DEF = 4;

  // Fixed field widths of the ports
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 4;
  localparam int COUNT_W    = 3;
  localparam int MASK_W     = 4;
  localparam int POS_W      = 5;
  localparam int WORD_IDX_W = 4;
  localparam int CH_IDX_W   = 3;
  localparam int EN_W       = 8;

  localparam logic [15:0] CRC_INIT  = 16'hFFFF;
  localparam logic [31:0] ERR_RESET = 32'h4000_0000;
  localparam logic [31:0] ERR_CRC   = 32'h8000_0000;
  localparam int          RESET_FLAG_BIT = 2;

  // Configuration register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_CHANNEL_COUNT  = 2'd0,
    REG_CHANNEL_MASK   = 2'd1,
    REG_PROBE_ATTACHED = 2'd2,
    REG_UNUSED         = 2'd3
  } afccu_reg_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_EMIT_CH,
    ST_EMIT_SUM
  } afccu_state_t;

  // Commands from the controller to the datapath
  typedef struct packed {
    logic                take_byte;
    logic                take_restart;
    logic                emit_load;
    logic                emit_sum;
    logic                emit_last;
    logic [CH_IDX_W-1:0] idx;
  } afccu_cmd_t;

  // Status from the datapath to the controller
  typedef struct packed {
    logic               frame_end;
    logic               good;
    logic               probe;
    logic               slot_free;
    logic [COUNT_W-1:0] count;
    logic [EN_W-1:0]    enabled;
  } afccu_sts_t;

  // One byte of CRC-16, poly 0x1021, no reflection
  function automatic logic [15:0] crc_step(input logic [15:0] crc, input logic [7:0] b);
    logic [7:0] x;
    x = crc[15:8] ^ b;
    x = x ^ (x >> 4);
    crc_step = (crc << 8) ^ ({8'h00, x} << 12) ^ ({8'h00, x} << 5) ^ {8'h00, x};
  endfunction

endpackage

/* sv/afccu_ctrl.sv */
// Controller: accepts transactions and walks the channels at frame end.
module afccu_ctrl import afccu_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic       in_kind,
  input  afccu_sts_t sts,
  output afccu_cmd_t cmd
);

  afccu_state_t        state_r, state_nxt;
  logic [CH_IDX_W-1:0] idx_r, idx_nxt;
  logic [EN_W-1:0]     above;
  logic                later;
  logic                sum_due;

  // Hold state and channel index
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      idx_r   <= '0;
    end else begin
      state_r <= state_nxt;
      idx_r   <= idx_nxt;
    end
  end

  assign above   = EN_W'(8'hFE) << idx_r;
  assign later   = |(sts.enabled & above);
  assign sum_due = sts.good && sts.probe;

  // Next state and commands
  always_comb begin
    state_nxt        = state_r;
    idx_nxt          = idx_r;
    in_ready         = 1'b0;
    cmd              = '0;
    cmd.idx          = idx_r;
    unique case (state_r)
      ST_IDLE: begin
        in_ready         = 1'b1;
        cmd.take_byte    = in_valid && !in_kind;
        cmd.take_restart = in_valid && in_kind;
        if (cmd.take_byte && sts.frame_end) begin
          idx_nxt   = '0;
          state_nxt = ST_EMIT_CH;
        end
      end
      ST_EMIT_CH: begin
        if (idx_r == sts.count) begin
          state_nxt = sum_due ? ST_EMIT_SUM : ST_IDLE;
        end else if (sts.enabled[idx_r]) begin
          if (sts.slot_free) begin
            cmd.emit_load = 1'b1;
            cmd.emit_last = !later && !sum_due;
            idx_nxt       = idx_r + 1'b1;
          end
        end else begin
          idx_nxt = idx_r + 1'b1;
        end
      end
      ST_EMIT_SUM: begin
        if (sts.slot_free) begin
          cmd.emit_load = 1'b1;
          cmd.emit_sum  = 1'b1;
          cmd.emit_last = 1'b1;
          state_nxt     = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

endmodule

/* sv/afccu_dp.sv */
// Datapath: config registers, CRC, word assembly, sum and output register.
module afccu_dp import afccu_pkg::*; #(
  parameter int MAX_CHANNELS = MAX_CHANNELS_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  cfg_valid,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  input  logic [7:0]            in_frame_byte,
  input  logic                  in_first,
  input  afccu_cmd_t            cmd,
  output afccu_sts_t            sts,
  output logic                  out_valid,
  input  logic                  out_ready,
  output logic signed [31:0]    out_value,
  output logic [1:0]            out_channel,
  output logic                  out_is_sum,
  output logic                  out_last
);

  localparam int CIW = (MAX_CHANNELS > 1) ? $clog2(MAX_CHANNELS) : 1;
  localparam logic [COUNT_W-1:0] MAX_CNT =
    (MAX_CHANNELS > 7) ? COUNT_W'(7) : COUNT_W'(MAX_CHANNELS);

  logic [COUNT_W-1:0]    channel_count_r;
  logic [MASK_W-1:0]     channel_mask_r;
  logic                  probe_r;
  logic [15:0]           crc_r, crc_nxt;
  logic [POS_W-1:0]      pos_r, pos_nxt;
  logic [1:0]            sub_r, sub_nxt;
  logic [WORD_IDX_W-1:0] word_r, word_nxt;
  logic [15:0]           rcrc_r, rcrc_nxt;
  logic                  latch_r, latch_nxt;
  logic [23:0]           chw_r [MAX_CHANNELS];
  logic [31:0]           sum_r;
  logic                  out_valid_r;
  logic [31:0]           out_value_r;
  logic [1:0]            out_channel_r;
  logic                  out_is_sum_r;
  logic                  out_last_r;

  logic [COUNT_W-1:0]    count;
  logic [POS_W-1:0]      frm_len, crc_off;
  logic [POS_W-1:0]      p;
  logic [1:0]            sub_eff;
  logic [WORD_IDX_W-1:0] word_eff, ch_w;
  logic [15:0]           crc_eff;
  logic                  in_frame, in_body;
  logic [23:0]           rd_word;
  logic [31:0]           ch_value;

  // Effective channel count and frame geometry
  always_comb begin
    count = channel_count_r;
    if (count == '0) count = COUNT_W'(1);
    if (count > MAX_CNT) count = MAX_CNT;
  end
  assign frm_len = POS_W'(count) + (POS_W'(count) << 1) + POS_W'(6);
  assign crc_off = frm_len - POS_W'(3);

  // First mark restarts position and CRC before the byte is taken
  assign p        = in_first ? '0 : pos_r;
  assign sub_eff  = in_first ? '0 : sub_r;
  assign word_eff = in_first ? '0 : word_r;
  assign crc_eff  = in_first ? CRC_INIT : crc_r;
  assign in_frame = p < frm_len;
  assign in_body  = p < crc_off;
  assign ch_w     = word_eff - WORD_IDX_W'(1);

  // Byte and restart processing
  always_comb begin
    crc_nxt   = crc_r;
    pos_nxt   = pos_r;
    sub_nxt   = sub_r;
    word_nxt  = word_r;
    rcrc_nxt  = rcrc_r;
    latch_nxt = latch_r;
    if (cmd.take_restart) begin
      latch_nxt = 1'b0;
    end else if (cmd.take_byte) begin
      crc_nxt  = crc_eff;
      pos_nxt  = p;
      sub_nxt  = sub_eff;
      word_nxt = word_eff;
      if (in_frame) begin
        if (in_body) begin
          crc_nxt = crc_step(crc_eff, in_frame_byte);
          if (p == '0 && in_frame_byte[RESET_FLAG_BIT]) latch_nxt = 1'b1;
        end else if (p == crc_off) begin
          rcrc_nxt = {in_frame_byte, 8'h00};
        end else if (p == crc_off + POS_W'(1)) begin
          rcrc_nxt = {rcrc_r[15:8], in_frame_byte};
        end
        pos_nxt = p + POS_W'(1);
        if (sub_eff == 2'd2) begin
          sub_nxt  = '0;
          word_nxt = word_eff + WORD_IDX_W'(1);
        end else begin
          sub_nxt = sub_eff + 2'd1;
        end
      end
    end
  end

  // Hold config and frame state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      channel_count_r <= COUNT_W'(2);
      channel_mask_r  <= MASK_W'(3);
      probe_r         <= 1'b0;
      crc_r           <= CRC_INIT;
      pos_r           <= '0;
      sub_r           <= '0;
      word_r          <= '0;
      rcrc_r          <= '0;
      latch_r         <= 1'b0;
    end else begin
      if (cfg_valid) begin
        unique case (afccu_reg_t'(cfg_index))
          REG_CHANNEL_COUNT:  channel_count_r <= cfg_data[COUNT_W-1:0];
          REG_CHANNEL_MASK:   channel_mask_r  <= cfg_data[MASK_W-1:0];
          REG_PROBE_ATTACHED: probe_r         <= cfg_data[0];
          default: ;
        endcase
      end
      crc_r   <= crc_nxt;
      pos_r   <= pos_nxt;
      sub_r   <= sub_nxt;
      word_r  <= word_nxt;
      rcrc_r  <= rcrc_nxt;
      latch_r <= latch_nxt;
    end
  end

  // Shift channel bytes into their word
  always_ff @(posedge clk) begin
    if (cmd.take_byte && in_frame && in_body && word_eff != '0) begin
      chw_r[ch_w[CIW-1:0]] <= {chw_r[ch_w[CIW-1:0]][15:0], in_frame_byte};
    end
  end

  // Select the value for the channel under emission
  assign rd_word  = chw_r[cmd.idx[CIW-1:0]];
  assign ch_value = sts.good ? {{8{rd_word[23]}}, rd_word}
                             : (latch_r ? ERR_RESET : ERR_CRC);

  // Clear the sum at frame end, add each reported channel
  always_ff @(posedge clk) begin
    if (cmd.take_byte && sts.frame_end) begin
      sum_r <= '0;
    end else if (cmd.emit_load && !cmd.emit_sum) begin
      sum_r <= sum_r + ch_value;
    end
  end

  // Output register: load when free, drop when taken
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.emit_load) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit_load) begin
      out_value_r   <= cmd.emit_sum ? sum_r : ch_value;
      out_channel_r <= cmd.emit_sum ? 2'd0 : cmd.idx[1:0];
      out_is_sum_r  <= cmd.emit_sum;
      out_last_r    <= cmd.emit_last;
    end
  end

  // Status toward the controller
  always_comb begin
    sts           = '0;
    sts.frame_end = in_frame && (p == frm_len - POS_W'(1));
    sts.good      = !latch_r && (crc_r == rcrc_r);
    sts.probe     = probe_r;
    sts.slot_free = !out_valid_r || out_ready;
    sts.count     = count;
    sts.enabled   = EN_W'(channel_mask_r) & ((EN_W'(1) << count) - EN_W'(1));
  end

  assign out_valid   = out_valid_r;
  assign out_value   = out_value_r;
  assign out_channel = out_channel_r;
  assign out_is_sum  = out_is_sum_r;
  assign out_last    = out_last_r;

endmodule

/* sv/adc_frame_crc_check_unpack_core.sv */
// Top level of the ADC frame CRC checker and unpacker.
// Takes one frame byte or restart per input transaction; outside a frame end
// in_ready is high. A frame is a status word, one 3-byte word per channel
// and a CRC word; the CRC-16 (init 0xFFFF, poly 0x1021) covers status and
// channel bytes. At the frame's last byte the sequencer walks the channel
// indexes, one per cycle unless a result waits on out_ready, closes the walk,
// then emits the channel sum when it is due. So in_ready stays low for the
// walk over the effective channel count (channel_count held to
// 1..MAX_CHANNELS, at most 7), for the sum and while a result waits on
// out_ready. Each channel result is the sign-extended 24-bit channel word,
// 0x40000000 for a latched device reset or 0x80000000 for a CRC mismatch;
// the sum result is their total and out_last marks the frame's final result.
// A result waits in the output register while new bytes are taken.
// Configuration writes are always accepted (cfg_ready is tied high).
module adc_frame_crc_check_unpack_core import afccu_pkg::*; #(
  parameter int MAX_CHANNELS = MAX_CHANNELS_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  logic                  in_kind,
  input  logic [7:0]            in_frame_byte,
  input  logic                  in_first,
  output logic                  out_valid,
  input  logic                  out_ready,
  output logic signed [31:0]    out_value,
  output logic [1:0]            out_channel,
  output logic                  out_is_sum,
  output logic                  out_last
);

  afccu_cmd_t cmd;
  afccu_sts_t sts;

  assign cfg_ready = 1'b1;

  afccu_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_kind  (in_kind),
    .sts      (sts),
    .cmd      (cmd)
  );

  afccu_dp #(
    .MAX_CHANNELS (MAX_CHANNELS)
  ) u_dp (
    .clk           (clk),
    .rst_n         (rst_n),
    .cfg_valid     (cfg_valid),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .in_frame_byte (in_frame_byte),
    .in_first      (in_first),
    .cmd           (cmd),
    .sts           (sts),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .out_value     (out_value),
    .out_channel   (out_channel),
    .out_is_sum    (out_is_sum),
    .out_last      (out_last)
  );

  // A sum result is always the frame's last, on channel zero
  a_sum_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_is_sum |-> out_last && out_channel == 2'd0)
    else $error("sum result not last or not on channel zero");

  // A restart transaction leaves a waiting result in place
  a_restart_quiet: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready && in_kind && out_valid && !out_ready |=> out_valid)
    else $error("restart disturbed a waiting result");

  // A result is only loaded while input is refused
  a_load_busy: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.emit_load |-> !in_ready)
    else $error("result loaded while accepting input");

  // Input is refused during the cycle after a frame's last byte
  a_end_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready && !in_kind && sts.frame_end |=> !in_ready)
    else $error("input accepted right after a frame end");

endmodule
